// File: design/olide_pkg.sv
`default_nettype none
package olide_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AT    = 3'd1,
    OP_INS_LEFT  = 3'd2,
    OP_INS_BACK  = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_DEL_VAL   = 3'd6,
    OP_READOUT   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_EMPTY = 3'd1,
    STS_NOPOS = 3'd2,
    STS_NOVAL = 3'd3,
    STS_FULL  = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic readout;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: design/olide_ram.sv
`default_nettype none
module olide_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: design/olide_ctrl.sv
`default_nettype none
module olide_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire olide_pkg::dp_sts_t   sts,
  output olide_pkg::ctrl_cmd_t      cmd
);
  import olide_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_TAIL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.need_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_TAIL;
        end
      end
      // last read response is consumed here; read out is then complete
      S_TAIL: begin
        state_nxt = sts.readout ? S_IDLE : S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// File: design/olide_dp.sv
`default_nettype none
module olide_dp #(
  parameter int unsigned CAPACITY = olide_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire olide_pkg::ctrl_cmd_t cmd,
  output olide_pkg::dp_sts_t        sts,
  input  wire logic [2:0]           in_operation,
  input  wire logic signed [31:0]   in_item_value,
  input  wire logic signed [5:0]    in_position,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic signed [31:0]        out_value,
  output logic                      out_last_of_run,
  output logic [4:0]                out_entry_count
);
  import olide_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = ((CW > 6) ? CW : 6) + 2;

  logic [CW-1:0]     count_r, count_nxt;
  op_t               op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] carry_r, carry_nxt;
  logic              found_r, found_nxt;
  status_t           st_r, st_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic              rv_r, rv_nxt;
  logic [AW-1:0]     ra_r, ra_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;
  logic [4:0]        out_count_r, out_count_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // request decode
  op_t               op_in;
  logic              empty, full;
  logic [AW-1:0]     cnt_m1;
  logic signed [SW-1:0] pos_s, q_s, n_s;
  status_t           dec_st;
  logic [AW-1:0]     dec_lo, dec_hi;
  logic              dec_scan;

  status_t           fin_st;
  logic [CW-1:0]     fin_count;

  assign op_in  = op_t'(in_operation);
  assign empty  = (count_r == '0);
  assign full   = (count_r >= CW'(CAPACITY));
  assign cnt_m1 = AW'(count_r - 1'b1);
  assign pos_s  = SW'(in_position);
  assign n_s    = $signed(SW'(count_r));
  assign q_s    = (op_in == OP_INS_LEFT) ? (pos_s - SW'(1)) : pos_s;

  always_comb begin
    dec_st   = STS_OK;
    dec_lo   = '0;
    dec_hi   = AW'(count_r);
    dec_scan = 1'b0;
    unique case (op_in)
      OP_INS_FRONT, OP_INS_AT, OP_INS_LEFT, OP_INS_BACK: begin
        if (full) begin
          dec_st = STS_FULL;
        end else begin
          dec_scan = 1'b1;
          priority if (op_in == OP_INS_FRONT) begin
            dec_lo = '0;
          end else if (op_in == OP_INS_BACK) begin
            dec_lo = AW'(count_r);
          end else if (op_in == OP_INS_LEFT && pos_s <= 2) begin
            dec_lo = '0;
          end else if (q_s == 1) begin
            dec_lo = '0;
          end else if (empty) begin
            dec_st   = STS_NOPOS;
            dec_scan = 1'b0;
          end else if (q_s <= 2) begin
            dec_lo = AW'(1);
          end else if (q_s > n_s + 1) begin
            dec_st   = STS_NOPOS;
            dec_scan = 1'b0;
          end else begin
            dec_lo = AW'(q_s - 1);
          end
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          dec_st = STS_EMPTY;
        end else begin
          dec_lo   = AW'(1);
          dec_hi   = cnt_m1;
          dec_scan = (count_r > CW'(1));
        end
      end
      OP_DEL_BACK: begin
        if (empty) begin
          dec_st = STS_EMPTY;
        end
      end
      OP_DEL_VAL, OP_READOUT: begin
        if (empty) begin
          dec_st = STS_EMPTY;
        end else begin
          dec_hi   = cnt_m1;
          dec_scan = 1'b1;
        end
      end
      default: begin
        dec_st = STS_OK;
      end
    endcase
  end

  always_comb begin
    fin_st = st_r;
    if (st_r == STS_OK && op_r == OP_DEL_VAL && !found_r) begin
      fin_st = STS_NOVAL;
    end
    fin_count = count_r;
    if (fin_st == STS_OK) begin
      unique case (op_r)
        OP_INS_FRONT, OP_INS_AT, OP_INS_LEFT, OP_INS_BACK: fin_count = count_r + 1'b1;
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_VAL:             fin_count = count_r - 1'b1;
        default:                                           fin_count = count_r;
      endcase
    end
  end

  always_comb begin
    count_nxt      = count_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    carry_nxt      = carry_r;
    found_nxt      = found_r;
    st_nxt         = st_r;
    ptr_nxt        = ptr_r;
    hi_nxt         = hi_r;
    rv_nxt         = cmd.issue;
    ra_nxt         = ptr_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = ra_r;
    ram_wdata      = carry_r;

    if (cmd.load) begin
      op_nxt    = op_in;
      val_nxt   = in_item_value;
      carry_nxt = in_item_value;
      found_nxt = (op_in == OP_DEL_FRONT);
      st_nxt    = dec_st;
      ptr_nxt   = dec_lo;
      hi_nxt    = dec_hi;
    end

    if (cmd.issue) begin
      ptr_nxt = ptr_r + 1'b1;
    end

    // consume one read response per cycle
    if (rv_r) begin
      unique case (op_r)
        OP_INS_FRONT, OP_INS_AT, OP_INS_LEFT, OP_INS_BACK: begin
          // ripple the new value in, push the old one up by one slot
          ram_we    = 1'b1;
          ram_waddr = ra_r;
          ram_wdata = carry_r;
          carry_nxt = ram_rdata;
        end
        OP_DEL_FRONT, OP_DEL_VAL: begin
          if (found_r) begin
            ram_we    = 1'b1;
            ram_waddr = ra_r - 1'b1;
            ram_wdata = ram_rdata;
          end else if (ram_rdata == val_r) begin
            found_nxt = 1'b1;
          end
        end
        OP_READOUT: begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          out_value_nxt  = ram_rdata;
          out_last_nxt   = (ra_r == hi_r);
          out_count_nxt  = 5'(count_r);
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end

    if (cmd.finish) begin
      count_nxt      = fin_count;
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_st;
      out_value_nxt  = '0;
      out_last_nxt   = 1'b1;
      out_count_nxt  = 5'(fin_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    carry_r      <= carry_nxt;
    found_r      <= found_nxt;
    st_r         <= st_nxt;
    ptr_r        <= ptr_nxt;
    hi_r         <= hi_nxt;
    ra_r         <= ra_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  olide_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ptr_r),
    .rd_data (ram_rdata)
  );

  assign sts.need_scan = dec_scan;
  assign sts.scan_last = (ptr_r == hi_r);
  assign sts.readout   = (op_r == OP_READOUT);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value       = $signed(out_value_r);
  assign out_last_of_run = out_last_r;
  assign out_entry_count = out_count_r;

endmodule
`default_nettype wire

// File: design/ordered_list_insert_delete_engine_unit.sv
`default_nettype none
// Flow: a request that touches no entries (error, delete back, single-entry delete front)
//   goes from idle straight to finish; others first walk k entries in the scan and tail states.
// Requests: busy until each is answered, walking entries through the single store read port.
// Read out: one element per cycle via store read and output registers; no final extra result.
// Reset: synchronous, active-low rst_n empties the list; store contents are left as they were.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
module ordered_list_insert_delete_engine_unit #(
  parameter int unsigned CAPACITY = olide_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_operation,
  input  wire logic signed [31:0] in_item_value,
  input  wire logic signed [5:0]  in_position,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_value,
  output logic                    out_last_of_run,
  output logic [4:0]              out_entry_count
);
  import olide_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  olide_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  olide_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_item_value   (in_item_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_last_of_run (out_last_of_run),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire
